FILE: sv/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: sv/ibfp_pkg.sv
// shared types and constants of the imu bcd frame parser
package ibfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 19;
    localparam int MAG_W       = 18;
    localparam int NUM_PAYLOAD = 9;
    localparam int GROUP_BYTES = 3;
    localparam int NUM_GROUPS  = NUM_PAYLOAD / GROUP_BYTES;
    localparam int PAY_IDX_W   = $clog2(NUM_PAYLOAD);
    localparam int TDATA_OUT_W = ((BYTE_W + NUM_GROUPS * VALUE_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W  = 8;

    localparam logic [BYTE_W-1:0] HEADER_RESET   = 8'h68;
    localparam logic [BYTE_W-1:0] DATA_CMD_RESET = 8'h84;
    localparam logic [BYTE_W-1:0] REPLY_ID_A     = 8'h8c;
    localparam logic [BYTE_W-1:0] REPLY_ID_B     = 8'h8b;
    localparam logic [BYTE_W-1:0] REPLY_ID_C     = 8'h28;

    localparam logic [BYTE_W-1:0] POS_LENGTH    = 8'd1;
    localparam logic [BYTE_W-1:0] POS_FIRST     = 8'd2;
    localparam logic [BYTE_W-1:0] POS_CMD       = 8'd3;
    localparam logic [BYTE_W-1:0] POS_PAY_FIRST = 8'd4;
    localparam logic [BYTE_W-1:0] POS_PAY_LAST  = 8'd12;
    localparam logic [BYTE_W-1:0] MIN_CMD_LEN   = 8'd4;
    localparam logic [BYTE_W-1:0] MIN_DATA_LEN  = 8'd13;

    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DATA_CMD = 8'd1;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef logic [NUM_PAYLOAD-1:0][BYTE_W-1:0] t_payload;
    typedef logic [GROUP_BYTES-1:0][BYTE_W-1:0] t_group;

    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] data_cmd;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic              kind;
        logic [BYTE_W-1:0] cmd;
    } t_frame_done;

endpackage

FILE: sv/ibfp_frame_fsm.sv
// frame tracker: header hunt, length, checksum, command and payload capture
module ibfp_frame_fsm
    import ibfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_frame_done       o_done,
    output t_payload          o_payload
);

    logic              r_in_frame, n_in_frame;
    logic [BYTE_W-1:0] r_pos, n_pos;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    t_payload          r_payload;

    logic                 w_body;
    logic [PAY_IDX_W-1:0] w_pay_off;
    logic                 w_reply;

    assign w_body    = r_in_frame && (r_pos != POS_LENGTH) && (r_pos < r_len);
    assign w_pay_off = PAY_IDX_W'(r_pos - POS_PAY_FIRST);
    assign w_reply   = (r_cmd == REPLY_ID_A) || (r_cmd == REPLY_ID_B) || (r_cmd == REPLY_ID_C);

    always_comb begin
        n_in_frame  = r_in_frame;
        n_pos       = r_pos;
        n_len       = r_len;
        n_sum       = r_sum;
        n_cmd       = r_cmd;
        o_done.hit  = 1'b0;
        o_done.kind = KIND_DATA;
        o_done.cmd  = r_cmd;
        if (i_step) begin
            if (!r_in_frame) begin
                if (i_byte == i_cfg.header) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_LENGTH;
                    n_sum      = '0;
                end
            end else if (r_pos == POS_LENGTH) begin
                n_len = i_byte;
                if (i_byte < MIN_CMD_LEN) begin
                    // too short to carry a command, back to hunting
                    n_in_frame = 1'b0;
                    n_pos      = '0;
                end else begin
                    n_sum = i_byte;
                    n_pos = POS_FIRST;
                end
            end else if (r_pos < r_len) begin
                n_sum = r_sum + i_byte;
                if (r_pos == POS_CMD) begin
                    n_cmd = i_byte;
                end
                n_pos = r_pos + 8'd1;
            end else begin
                // checksum word closes the frame
                n_in_frame = 1'b0;
                n_pos      = '0;
                if (r_sum == i_byte) begin
                    if (r_cmd == i_cfg.data_cmd) begin
                        o_done.hit  = (r_len >= MIN_DATA_LEN);
                        o_done.kind = KIND_DATA;
                    end else if (w_reply) begin
                        o_done.hit  = 1'b1;
                        o_done.kind = KIND_REPLY;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_len      <= '0;
            r_sum      <= '0;
            r_cmd      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_sum      <= n_sum;
            r_cmd      <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && w_body && (r_pos >= POS_PAY_FIRST) && (r_pos <= POS_PAY_LAST)) begin
            r_payload[w_pay_off] <= i_byte;
        end
    end

    assign o_payload = r_payload;

endmodule

FILE: sv/ibfp_bcd_group.sv
// one sign nibble and five bcd digits to a signed 19 bit value
module ibfp_bcd_group
    import ibfp_pkg::*;
(
    input  t_group                     i_bytes,
    output logic signed [VALUE_W-1:0]  o_value
);

    logic [3:0]       w_sign;
    logic [3:0]       w_d1, w_d2, w_d3, w_d4, w_d5;
    logic [MAG_W-1:0] w_mag;

    assign w_sign = i_bytes[0][7:4];
    assign w_d1   = i_bytes[0][3:0];
    assign w_d2   = i_bytes[1][7:4];
    assign w_d3   = i_bytes[1][3:0];
    assign w_d4   = i_bytes[2][7:4];
    assign w_d5   = i_bytes[2][3:0];

    // digits are weighted as given, even above nine
    assign w_mag = MAG_W'(w_d1) * MAG_W'(10000) + MAG_W'(w_d2) * MAG_W'(1000)
                 + MAG_W'(w_d3) * MAG_W'(100) + MAG_W'(w_d4) * MAG_W'(10)
                 + MAG_W'(w_d5);

    assign o_value = (w_sign == 4'd1) ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

endmodule

FILE: sv/imu_bcd_frame_parser_unit.sv
// top level of the imu bcd frame parser
//
// channel  dir  handshake              payload
// s        in   i_s_tvalid/o_s_tready  i_s_tdata: rx_byte
// m        out  o_m_tvalid/i_m_tready  o_m_tdata, o_m_tuser: decoded frame
// cfg      in   i_cfg_valid/o_cfg_ready i_cfg_addr, i_cfg_data
//
// one word per cycle while the result is not stalled: input register, one pass of frame logic, result register
// a result passes the input register and then the result register once the checksum word is taken
// reset (synchronous, active low) clears parse state and config to defaults
// a stalled result holds its register; input is still accepted until the input
// register is also full
module imu_bcd_frame_parser_unit
    import ibfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [BYTE_W-1:0]      i_s_tdata,    // [7:0] rx_byte
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0] o_m_tdata,    // [7:0] command_id, [26:8] rate_centi,
                                                 // [45:27] accel_milli_g,
                                                 // [64:46] heading_centi, rest zero
    output logic                   o_m_tuser,    // [0] frame_kind
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [BYTE_W-1:0]      i_cfg_data
);

    t_cfg                       r_cfg;
    logic                       r_in_valid;
    logic [BYTE_W-1:0]          r_in_byte;
    logic                       r_out_valid;
    logic                       r_out_kind;
    logic [BYTE_W-1:0]          r_out_cmd;
    logic signed [VALUE_W-1:0]  r_out_val [NUM_GROUPS];

    logic                       w_advance;
    logic                       w_step;
    t_frame_done                w_done;
    t_payload                   w_payload;
    logic signed [VALUE_W-1:0]  w_grp [NUM_GROUPS];

    assign w_advance   = !r_out_valid || i_m_tready;
    assign w_step      = r_in_valid && w_advance;
    assign o_s_tready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header   <= HEADER_RESET;
            r_cfg.data_cmd <= DATA_CMD_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_addr == CFG_HEADER) begin
                r_cfg.header <= i_cfg_data;
            end else if (i_cfg_addr == CFG_DATA_CMD) begin
                r_cfg.data_cmd <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    ibfp_frame_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_byte    (r_in_byte),
        .i_cfg     (r_cfg),
        .o_done    (w_done),
        .o_payload (w_payload)
    );

    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        ibfp_bcd_group u_grp (
            .i_bytes (w_payload[g*GROUP_BYTES +: GROUP_BYTES]),
            .o_value (w_grp[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_done.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_done.hit) begin
            r_out_kind <= w_done.kind;
            r_out_cmd  <= w_done.cmd;
            for (int k = 0; k < NUM_GROUPS; k++) begin
                // reply frames carry no readings
                r_out_val[k] <= (w_done.kind == KIND_REPLY) ? '0 : w_grp[k];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = TDATA_OUT_W'({r_out_val[2], r_out_val[1], r_out_val[0], r_out_cmd});

`include "assert_macros.svh"

    `ASSERT_HOLDS(a_result_from_step, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_step))
    `ASSERT_HOLDS(a_in_reg_kept, i_clk, i_rst_n, (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
    `ASSERT_NEVER(a_reply_no_values, i_clk, i_rst_n, r_out_valid && (r_out_kind == KIND_REPLY) && ((r_out_val[0] != '0) || (r_out_val[1] != '0) || (r_out_val[2] != '0)))
    `ASSERT_NEVER(a_data_cmd_match, i_clk, i_rst_n, r_out_valid && (r_out_kind == KIND_DATA) && (r_out_cmd != r_cfg.data_cmd))

endmodule

FILE: test/imu_bcd_frame_parser_unit_tb.sv
// self-checking testbench for the imu bcd frame parser with a frame predictor and scoreboard
`timescale 1ns / 100ps

module imu_bcd_frame_parser_unit_tb;
    import ibfp_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_BYTES  = 260;
    localparam int NUM_PHASES   = 5;

    typedef struct {
        logic               kind;
        logic [BYTE_W-1:0]  cmd;
        logic [VALUE_W-1:0] rate;
        logic [VALUE_W-1:0] accel;
        logic [VALUE_W-1:0] heading;
    } t_imu_frame;

    class imu_frame_scoreboard;
        t_cfg              cfg = '{HEADER_RESET, DATA_CMD_RESET};
        int                fail_count = 0;
        t_imu_frame        frames_due[$];
        logic              in_frame = 1'b0;
        logic [BYTE_W-1:0] pos = '0;
        logic [BYTE_W-1:0] flen = '0;
        logic [BYTE_W-1:0] sum = '0;
        logic [BYTE_W-1:0] cmd = '0;
        t_payload          pay = '0;

        task report(string what);
            fail_count++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [BYTE_W-1:0] val);
            if (idx == CFG_HEADER) cfg.header = val;
            else if (idx == CFG_DATA_CMD) cfg.data_cmd = val;
        endfunction

        // payload nibble k, even k is the high nibble
        function logic [3:0] nibble(int k);
            logic [BYTE_W-1:0] b;
            b = pay[k / 2];
            return (k % 2 == 0) ? b[7:4] : b[3:0];
        endfunction

        // sign nibble then five digits, most significant first
        function logic [VALUE_W-1:0] bcd_group(int k);
            logic [MAG_W-1:0] mag;
            mag = '0;
            for (int d = 1; d <= 5; d++) mag = MAG_W'(mag * 10 + nibble(k + d));
            return (nibble(k) == 4'd1) ? VALUE_W'(0) - {1'b0, mag} : {1'b0, mag};
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b);
            t_imu_frame f;
            if (!in_frame) begin
                if (b == cfg.header) begin
                    in_frame = 1'b1;
                    pos = POS_LENGTH;
                    sum = '0;
                end
                return;
            end
            if (pos == POS_LENGTH) begin
                flen = b;
                if (b < MIN_CMD_LEN) begin
                    in_frame = 1'b0;
                    pos = '0;
                    return;
                end
                sum = b;
                pos = POS_FIRST;
                return;
            end
            if (pos < flen) begin
                sum += b;
                if (pos == POS_CMD) cmd = b;
                if (pos >= POS_PAY_FIRST && pos <= POS_PAY_LAST) pay[pos - POS_PAY_FIRST] = b;
                pos++;
                return;
            end
            // checksum word closes the frame
            in_frame = 1'b0;
            pos = '0;
            if (sum != b) return;
            f.cmd = cmd;
            if (cmd == cfg.data_cmd) begin
                if (flen < MIN_DATA_LEN) return;
                f.kind    = KIND_DATA;
                f.rate    = bcd_group(0);
                f.accel   = bcd_group(6);
                f.heading = bcd_group(12);
                frames_due.push_back(f);
            end else if (cmd == REPLY_ID_A || cmd == REPLY_ID_B || cmd == REPLY_ID_C) begin
                f.kind    = KIND_REPLY;
                f.rate    = '0;
                f.accel   = '0;
                f.heading = '0;
                frames_due.push_back(f);
            end
        endfunction

        task check_frame(logic [TDATA_OUT_W-1:0] td, logic tu);
            t_imu_frame want;
            logic [VALUE_W-1:0] rate, accel, heading;
            rate    = td[BYTE_W +: VALUE_W];
            accel   = td[BYTE_W + VALUE_W +: VALUE_W];
            heading = td[BYTE_W + 2 * VALUE_W +: VALUE_W];
            if (frames_due.size() == 0) begin
                report($sformatf("result cmd %02h with none pending", td[BYTE_W-1:0]));
                return;
            end
            want = frames_due.pop_front();
            if (tu !== want.kind)
                report($sformatf("frame_kind got %b want %b", tu, want.kind));
            if (td[BYTE_W-1:0] !== want.cmd)
                report($sformatf("command_id got %02h want %02h", td[BYTE_W-1:0], want.cmd));
            if (rate !== want.rate)
                report($sformatf("rate_centi got %0d want %0d",
                                 $signed(rate), $signed(want.rate)));
            if (accel !== want.accel)
                report($sformatf("accel_milli_g got %0d want %0d",
                                 $signed(accel), $signed(want.accel)));
            if (heading !== want.heading)
                report($sformatf("heading_centi got %0d want %0d",
                                 $signed(heading), $signed(want.heading)));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [BYTE_W-1:0]      i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [TDATA_OUT_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [BYTE_W-1:0]      i_cfg_data;

    imu_frame_scoreboard sb;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    logic s_quiet = 1'b0;
    logic m_quiet = 1'b0;

    imu_bcd_frame_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_gap(logic quiet);
        if (quiet || $urandom_range(0, 4) == 0) return 0;
        return $urandom_range(0, 14);
    endfunction

    // handshakes are sampled at the falling edge, where inputs and outputs are settled
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int   gap;
        logic got;
        gap = draw_gap(s_quiet);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do begin
            @(negedge i_clk);
            got = o_s_tready;
            @(posedge i_clk);
        end while (!got);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] cmd,
                              input t_payload pay, input logic corrupt);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        sum = len;
        send_byte(sb.cfg.header);
        send_byte(len);
        if (len < MIN_CMD_LEN) return;
        for (int i = POS_FIRST; i < len; i++) begin
            if (i == POS_CMD) b = cmd;
            else if (i >= POS_PAY_FIRST && i <= POS_PAY_LAST) b = pay[i - POS_PAY_FIRST];
            else b = BYTE_W'($urandom);
            sum += b;
            send_byte(b);
        end
        if (corrupt) sum ^= BYTE_W'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    // mostly sign 0/1 with decimal digits, some wild nibbles, now and then fully random
    function automatic t_payload bcd_payload();
        t_payload   pay;
        logic [3:0] n;
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < NUM_PAYLOAD; i++) pay[i] = BYTE_W'($urandom);
            return pay;
        end
        for (int i = 0; i < 2 * NUM_PAYLOAD; i++) begin
            if (i % 6 == 0)
                n = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 1))
                                               : 4'($urandom_range(0, 15));
            else
                n = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 9))
                                               : 4'($urandom_range(0, 15));
            if (i % 2 == 0) pay[i / 2][7:4] = n;
            else pay[i / 2][3:0] = n;
        end
        return pay;
    endfunction

    task automatic send_noise(input int count, input logic avoid_header);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < count; i++) begin
            b = BYTE_W'($urandom);
            if (avoid_header && b == sb.cfg.header) b ^= 8'h01;
            send_byte(b);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [BYTE_W-1:0] val);
        logic got;
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            got = o_cfg_ready;
            @(posedge i_clk);
        end while (!got);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // wait for every pending frame, then let the pipeline empty
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic directed_frames();
        t_payload pay;
        pay = '0;
        send_frame(8'd13, sb.cfg.data_cmd, pay, 1'b0);
        pay = {8'hff, 8'hff, 8'h1f, 8'h45, 8'h23, 8'h01, 8'h99, 8'h99, 8'h19};
        send_frame(8'd13, sb.cfg.data_cmd, pay, 1'b0);
        pay = {8'h01, 8'h00, 8'h20, 8'h99, 8'h99, 8'hf9, 8'hff, 8'hff, 8'h0f};
        send_frame(8'd13, sb.cfg.data_cmd, pay, 1'b0);
        send_frame(8'd4, REPLY_ID_A, pay, 1'b0);
        send_frame(8'd9, REPLY_ID_B, pay, 1'b0);
        send_frame(8'd13, REPLY_ID_C, pay, 1'b0);
        // bad checksum is dropped
        send_frame(8'd13, sb.cfg.data_cmd, bcd_payload(), 1'b1);
        send_noise(3, 1'b1);
        // length too short to hold a command
        send_frame(8'd0, sb.cfg.data_cmd, pay, 1'b0);
        send_frame(8'd3, sb.cfg.data_cmd, pay, 1'b0);
        // data frames too short for the payload
        send_frame(8'd12, sb.cfg.data_cmd, bcd_payload(), 1'b0);
        send_frame(8'd4, sb.cfg.data_cmd, bcd_payload(), 1'b0);
        send_frame(8'd13, 8'h55, bcd_payload(), 1'b0);
        // header value inside a frame is plain data
        pay = bcd_payload();
        pay[2] = sb.cfg.header;
        send_frame(8'd20, sb.cfg.header, pay, 1'b0);
        send_frame(8'd255, sb.cfg.data_cmd, bcd_payload(), 1'b0);
        send_frame(8'd13, sb.cfg.data_cmd, bcd_payload(), 1'b0);
    endtask

    task automatic random_traffic(input int count);
        int                start;
        int                r;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] cmd;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                len = ($urandom_range(0, 29) == 0) ? BYTE_W'($urandom_range(14, 255))
                                                    : BYTE_W'($urandom_range(13, 16));
                send_frame(len, sb.cfg.data_cmd, bcd_payload(), 1'b0);
            end else if (r < 65) begin
                case ($urandom_range(0, 2))
                    0: cmd = REPLY_ID_A;
                    1: cmd = REPLY_ID_B;
                    default: cmd = REPLY_ID_C;
                endcase
                send_frame(BYTE_W'($urandom_range(4, 16)), cmd, bcd_payload(), 1'b0);
            end else if (r < 72) begin
                send_frame(BYTE_W'($urandom_range(4, 16)), BYTE_W'($urandom), bcd_payload(),
                           1'b0);
            end else if (r < 80) begin
                cmd = ($urandom_range(0, 1) == 0) ? sb.cfg.data_cmd : REPLY_ID_B;
                send_frame(BYTE_W'($urandom_range(4, 16)), cmd, bcd_payload(), 1'b1);
            end else if (r < 85) begin
                send_frame(BYTE_W'($urandom_range(4, 12)), sb.cfg.data_cmd, bcd_payload(),
                           1'b0);
            end else if (r < 90) begin
                send_frame(BYTE_W'($urandom_range(0, 3)), sb.cfg.data_cmd, bcd_payload(),
                           1'b0);
            end else begin
                send_noise($urandom_range(1, 5), 1'b0);
            end
        end
    endtask

    // result side: ready drops for a drawn number of cycles once a word is offered
    initial begin
        int                     gap;
        logic                   got;
        logic [TDATA_OUT_W-1:0] td;
        logic                   tu;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap(m_quiet);
            if (gap == 0) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                do begin
                    @(negedge i_clk);
                    got = o_m_tvalid;
                    @(posedge i_clk);
                end while (!got);
                repeat (gap - 1) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
            do begin
                @(negedge i_clk);
                got = o_m_tvalid;
                td  = o_m_tdata;
                tu  = o_m_tuser;
                @(posedge i_clk);
            end while (!got);
            sb.check_frame(td, tu);
        end
    end

    initial begin
        logic [BYTE_W-1:0] hdr_set [NUM_PHASES];
        logic [BYTE_W-1:0] cmd_set [NUM_PHASES];
        hdr_set = '{8'h00, 8'hff, HEADER_RESET, 8'h00, HEADER_RESET};
        cmd_set = '{8'hff, 8'h00, REPLY_ID_A, 8'h00, DATA_CMD_RESET};
        sb = new;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings first
        directed_frames();
        random_traffic(PHASE_BYTES);
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            if (p == 3) begin
                hdr_set[p] = BYTE_W'($urandom);
                cmd_set[p] = BYTE_W'($urandom);
            end
            write_reg(CFG_HEADER, hdr_set[p]);
            write_reg(CFG_DATA_CMD, cmd_set[p]);
            s_quiet = ($urandom_range(0, 3) == 0);
            m_quiet = ($urandom_range(0, 3) == 0);
            random_traffic(PHASE_BYTES);
        end
        settle();

        if (sb.fail_count == 0 && sb.frames_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
